### rtl/core/time_of_day_clock_assert.svh
// ----------------------------------------------------------------------------
// time_of_day_clock assertion macros
// Concurrent assertion wrappers for the time-of-day clock; they compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_ASSERT_SVH

`ifndef SYNTH
// property checked on every edge outside reset
`define TOD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every edge outside reset
`define TOD_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`else
`define TOD_ASSERT(label, clk, rst_n, prop, msg)
`define TOD_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg)
`endif

`endif

### rtl/core/tod_pkg.sv
// ----------------------------------------------------------------------------
// tod_pkg
// Types and constants shared by the time-of-day clock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tod_pkg;

    // field and time widths
    localparam int FIELD_W = 32;
    localparam int TIME_W  = 17;
    localparam int REM_W   = 12;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int HRES_W  = 5;
    localparam int MRES_W  = 11;

    // clock constants
    localparam int DAY_SECONDS    = 86400;
    localparam int HOUR_SECONDS   = 3600;
    localparam int MINUTE_SECONDS = 60;
    localparam int MAX_HOUR       = 23;
    localparam int MAX_MINUTE     = 59;
    localparam int MAX_SECOND     = 59;

    // reduction divisors for the signed operands
    localparam longint unsigned TWO_POW_FIELD   = 64'h1_0000_0000;
    localparam longint unsigned HOURS_PER_DAY   = 24;
    localparam longint unsigned MINUTES_PER_DAY = 1440;
    localparam longint unsigned SECONDS_PER_DAY = 86400;

    // floor reciprocals scaled by 2^32, and 2^32 modulo each divisor
    localparam logic [FIELD_W-1:0] RECIP_HOURS   = FIELD_W'(TWO_POW_FIELD / HOURS_PER_DAY);
    localparam logic [FIELD_W-1:0] RECIP_MINUTES = FIELD_W'(TWO_POW_FIELD / MINUTES_PER_DAY);
    localparam logic [FIELD_W-1:0] RECIP_SECONDS = FIELD_W'(TWO_POW_FIELD / SECONDS_PER_DAY);
    localparam logic [FIELD_W-1:0] WRAP_HOURS    = FIELD_W'(TWO_POW_FIELD % HOURS_PER_DAY);
    localparam logic [FIELD_W-1:0] WRAP_MINUTES  = FIELD_W'(TWO_POW_FIELD % MINUTES_PER_DAY);
    localparam logic [FIELD_W-1:0] WRAP_SECONDS  = FIELD_W'(TWO_POW_FIELD % SECONDS_PER_DAY);

    // floor reciprocals for splitting a time into h:m:s
    localparam int RECIP_HOUR   = (1 << TIME_W) / HOUR_SECONDS;
    localparam int RECIP_MINUTE = (1 << REM_W) / MINUTE_SECONDS;

    // request kinds
    typedef enum logic [2:0] {
        KIND_SET_CHECKED = 3'd0,
        KIND_SET_NORM    = 3'd1,
        KIND_INC         = 3'd2,
        KIND_DEC         = 3'd3,
        KIND_ADD         = 3'd4,
        KIND_SUB         = 3'd5,
        KIND_DIFF        = 3'd6,
        KIND_CHECK       = 3'd7
    } kind_t;

    // reduced operands handed to the state stage
    typedef struct packed {
        kind_t             kind;
        logic              fields_ok;
        logic [TIME_W-1:0] t_given;
        logic [TIME_W-1:0] addend;
    } operand_t;

    // state stage result handed to the split stage
    typedef struct packed {
        logic [TIME_W-1:0]         now;
        logic                      invalid;
        logic signed [FIELD_W-1:0] diff;
    } state_result_t;

endpackage

`default_nettype wire

### rtl/core/time_of_day_clock.sv
// The clock keeps the time of day as seconds since midnight and answers every
// request with one result: the stored time as hours, minutes and seconds, an
// out-of-range flag for checked set and check, and for difference requests the
// stored time minus the given h:m:s. One request is taken per clock cycle while
// the pipeline is not stalled by back-pressure. A request passes seven register
// stages: a four-stage operand reduction, the update of the seconds register,
// which sets the rate, and a two-stage split into h:m:s that ends in the output
// register, where the result waits until the output is ready. Back-pressure stalls
// only the stages that are full, so requests keep flowing into empty stages while a
// result waits at the output.
// ----------------------------------------------------------------------------
// time_of_day_clock
// Top level of the time-of-day clock: operand reduction, state update and
// h:m:s split.
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_of_day_clock_assert.svh"

module time_of_day_clock (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire tod_pkg::kind_t                    kind,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] hours,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] minutes,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] seconds,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] offset,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tod_pkg::HOUR_W-1:0]             hour_now,
    output logic [tod_pkg::MIN_W-1:0]              minute_now,
    output logic [tod_pkg::MIN_W-1:0]              second_now,
    output logic                                   invalid,
    output logic signed [tod_pkg::FIELD_W-1:0]     difference
);
    import tod_pkg::*;

    logic          op_valid;
    logic          op_ready;
    operand_t      op;
    logic          res_valid;
    logic          res_ready;
    state_result_t res;

    // operand reduction
    tod_operand_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .hours    (hours),
        .minutes  (minutes),
        .seconds  (seconds),
        .offset   (offset),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // stored time update
    tod_state_update u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // h:m:s split and output register
    tod_hms_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hour_now   (hour_now),
        .minute_now (minute_now),
        .second_now (second_now),
        .invalid    (invalid),
        .difference (difference)
    );

    // stored time never leaves one day
    `TOD_ASSERT(a_time_in_day, clk, rst_n, res.now < TIME_W'(DAY_SECONDS), "stored time out of day")

    // reported fields lie on the clock face
    `TOD_ASSERT_IMPL(a_hms_range, clk, rst_n, out_valid,
        hour_now <= HOUR_W'(MAX_HOUR) && minute_now <= MIN_W'(MAX_MINUTE)
        && second_now <= MIN_W'(MAX_SECOND), "h:m:s out of range")

    // flagged requests never carry a difference
    `TOD_ASSERT_IMPL(a_flag_no_diff, clk, rst_n, out_valid && invalid, difference == '0,
        "difference set on flagged request")

    // difference stays within one day either way
    `TOD_ASSERT_IMPL(a_diff_range, clk, rst_n, out_valid,
        difference >= -FIELD_W'(DAY_SECONDS - 1) && difference <= FIELD_W'(DAY_SECONDS - 1),
        "difference out of range")

endmodule

`default_nettype wire

### rtl/core/tod_operand_reduce.sv
// ----------------------------------------------------------------------------
// tod_operand_reduce
// Four-stage pipeline that wraps the signed h:m:s fields and the offset
// modulo one day, independent of the stored time.
// ----------------------------------------------------------------------------
`default_nettype none

module tod_operand_reduce (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire tod_pkg::kind_t                 kind,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] hours,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] minutes,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] seconds,
    input  wire logic signed [tod_pkg::FIELD_W-1:0] offset,
    output logic                                op_valid,
    input  wire logic                           op_ready,
    output tod_pkg::operand_t                   op
);
    import tod_pkg::*;

    // floored residue of a 32-bit two's complement value from an estimated quotient
    function automatic logic [FIELD_W-1:0] floor_mod(
        input logic [FIELD_W-1:0] u,
        input logic [FIELD_W-1:0] q,
        input logic [FIELD_W-1:0] c,
        input logic [FIELD_W-1:0] w
    );
        logic [FIELD_W-1:0] r_est;
        logic [FIELD_W-1:0] r_u;
        r_est = u - FIELD_W'(q * c);
        r_u   = (r_est >= c) ? r_est - c : r_est;
        if (u[FIELD_W-1])
        begin
            r_u = (r_u >= w) ? r_u - w : r_u + c - w;
        end
        return r_u;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic load1, load2, load3, load4;

    kind_t              kind1_reg, kind2_reg, kind3_reg;
    logic               ok1_reg, ok2_reg, ok3_reg;
    logic [FIELD_W-1:0] h1_reg, m1_reg, s1_reg, o1_reg;
    logic [FIELD_W-1:0] h2_reg, m2_reg, s2_reg, o2_reg;
    logic [FIELD_W-1:0] qh2_reg, qm2_reg, qs2_reg, qo2_reg;
    logic [HRES_W-1:0]  rh3_reg;
    logic [MRES_W-1:0]  rm3_reg;
    logic [TIME_W-1:0]  rs3_reg, ro3_reg;
    operand_t           op_reg;

    logic               fields_ok;
    logic [2*FIELD_W-1:0] prod_h, prod_m, prod_s, prod_o;
    logic [FIELD_W-1:0] rh_full, rm_full, rs_full, ro_full;
    logic [TIME_W+1:0]  total;
    logic [TIME_W-1:0]  t_wrapped;
    logic [TIME_W-1:0]  addend;
    operand_t           op_next;

    // stage handshake, each stage loads when empty or draining
    assign load4    = !v4_reg || op_ready;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;
    assign op_valid = v4_reg;
    assign op       = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1) v1_reg <= in_valid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
        end
    end

    // range check of the raw fields
    assign fields_ok = (hours >= 0) && (hours <= MAX_HOUR) &&
                       (minutes >= 0) && (minutes <= MAX_MINUTE) &&
                       (seconds >= 0) && (seconds <= MAX_SECOND);

    // input register
    always_ff @(posedge clk)
    begin
        if (load1 && in_valid)
        begin
            kind1_reg <= kind;
            ok1_reg   <= fields_ok;
            h1_reg    <= hours;
            m1_reg    <= minutes;
            s1_reg    <= seconds;
            o1_reg    <= offset;
        end
    end

    // quotient estimates by reciprocal multiplication
    assign prod_h = (2*FIELD_W)'(h1_reg) * (2*FIELD_W)'(RECIP_HOURS);
    assign prod_m = (2*FIELD_W)'(m1_reg) * (2*FIELD_W)'(RECIP_MINUTES);
    assign prod_s = (2*FIELD_W)'(s1_reg) * (2*FIELD_W)'(RECIP_SECONDS);
    assign prod_o = (2*FIELD_W)'(o1_reg) * (2*FIELD_W)'(RECIP_SECONDS);

    always_ff @(posedge clk)
    begin
        if (load2 && v1_reg)
        begin
            kind2_reg <= kind1_reg;
            ok2_reg   <= ok1_reg;
            h2_reg    <= h1_reg;
            m2_reg    <= m1_reg;
            s2_reg    <= s1_reg;
            o2_reg    <= o1_reg;
            qh2_reg   <= prod_h[2*FIELD_W-1:FIELD_W];
            qm2_reg   <= prod_m[2*FIELD_W-1:FIELD_W];
            qs2_reg   <= prod_s[2*FIELD_W-1:FIELD_W];
            qo2_reg   <= prod_o[2*FIELD_W-1:FIELD_W];
        end
    end

    // residues with correction and sign fix
    assign rh_full = floor_mod(h2_reg, qh2_reg, FIELD_W'(HOURS_PER_DAY), WRAP_HOURS);
    assign rm_full = floor_mod(m2_reg, qm2_reg, FIELD_W'(MINUTES_PER_DAY), WRAP_MINUTES);
    assign rs_full = floor_mod(s2_reg, qs2_reg, FIELD_W'(SECONDS_PER_DAY), WRAP_SECONDS);
    assign ro_full = floor_mod(o2_reg, qo2_reg, FIELD_W'(SECONDS_PER_DAY), WRAP_SECONDS);

    always_ff @(posedge clk)
    begin
        if (load3 && v2_reg)
        begin
            kind3_reg <= kind2_reg;
            ok3_reg   <= ok2_reg;
            rh3_reg   <= rh_full[HRES_W-1:0];
            rm3_reg   <= rm_full[MRES_W-1:0];
            rs3_reg   <= rs_full[TIME_W-1:0];
            ro3_reg   <= ro_full[TIME_W-1:0];
        end
    end

    // total of the given time, wrapped by at most two days
    assign total = (TIME_W+2)'(rh3_reg) * (TIME_W+2)'(HOUR_SECONDS) +
                   (TIME_W+2)'(rm3_reg) * (TIME_W+2)'(MINUTE_SECONDS) +
                   (TIME_W+2)'(rs3_reg);

    always_comb
    begin
        if (total >= (TIME_W+2)'(2 * DAY_SECONDS))
        begin
            t_wrapped = TIME_W'(total - (TIME_W+2)'(2 * DAY_SECONDS));
        end
        else if (total >= (TIME_W+2)'(DAY_SECONDS))
        begin
            t_wrapped = TIME_W'(total - (TIME_W+2)'(DAY_SECONDS));
        end
        else
        begin
            t_wrapped = TIME_W'(total);
        end
    end

    // step to add to the stored time, already reduced to one day
    always_comb
    begin
        case (kind3_reg)
            KIND_INC: addend = TIME_W'(1);
            KIND_DEC: addend = TIME_W'(DAY_SECONDS - 1);
            KIND_ADD: addend = ro3_reg;
            KIND_SUB: addend = (ro3_reg == '0) ? '0 : TIME_W'(DAY_SECONDS) - ro3_reg;
            default:  addend = '0;
        endcase
    end

    always_comb
    begin
        op_next.kind      = kind3_reg;
        op_next.fields_ok = ok3_reg;
        op_next.t_given   = t_wrapped;
        op_next.addend    = addend;
    end

    always_ff @(posedge clk)
    begin
        if (load4 && v3_reg)
        begin
            op_reg <= op_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tod_state_update.sv
// ----------------------------------------------------------------------------
// tod_state_update
// Holds the seconds since midnight and applies one request per cycle unless the result is held by back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tod_state_update (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  op_valid,
    output logic                       op_ready,
    input  wire tod_pkg::operand_t     op,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output tod_pkg::state_result_t     res
);
    import tod_pkg::*;

    logic                      res_valid_reg;
    logic [TIME_W-1:0]         sod_reg;
    logic [TIME_W-1:0]         sod_next;
    logic                      invalid_reg;
    logic                      invalid_next;
    logic signed [FIELD_W-1:0] diff_reg;
    logic signed [FIELD_W-1:0] diff_next;
    logic                      load;
    logic [TIME_W:0]           sum;
    logic [TIME_W-1:0]         sum_wrapped;
    logic [TIME_W:0]           diff_short;

    assign load      = !res_valid_reg || res_ready;
    assign op_ready  = load;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        res.now     = sod_reg;
        res.invalid = invalid_reg;
        res.diff    = diff_reg;
    end

    // one-day wrap of the stored time plus the step
    assign sum         = {1'b0, sod_reg} + {1'b0, op.addend};
    assign sum_wrapped = (sum >= (TIME_W+1)'(DAY_SECONDS)) ?
                         TIME_W'(sum - (TIME_W+1)'(DAY_SECONDS)) : TIME_W'(sum);
    assign diff_short  = {1'b0, sod_reg} - {1'b0, op.t_given};

    // next time, flag and difference
    always_comb
    begin
        sod_next     = sod_reg;
        invalid_next = 1'b0;
        diff_next    = '0;
        case (op.kind)
            KIND_SET_CHECKED:
            begin
                if (op.fields_ok)
                begin
                    sod_next = op.t_given;
                end
                invalid_next = !op.fields_ok;
            end
            KIND_SET_NORM:
            begin
                sod_next = op.t_given;
            end
            KIND_INC, KIND_DEC, KIND_ADD, KIND_SUB:
            begin
                sod_next = sum_wrapped;
            end
            KIND_DIFF:
            begin
                diff_next = {{(FIELD_W-TIME_W-1){diff_short[TIME_W]}}, diff_short};
            end
            KIND_CHECK:
            begin
                invalid_next = !op.fields_ok;
            end
            default:
            begin
                sod_next = sod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sod_reg       <= '0;
        end
        else if (load)
        begin
            res_valid_reg <= op_valid;
            if (op_valid)
            begin
                sod_reg <= sod_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && op_valid)
        begin
            invalid_reg <= invalid_next;
            diff_reg    <= diff_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tod_hms_split.sv
// ----------------------------------------------------------------------------
// tod_hms_split
// Two-stage split of seconds since midnight into hours, minutes and seconds,
// ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tod_hms_split (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              res_valid,
    output logic                                   res_ready,
    input  wire tod_pkg::state_result_t            res,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tod_pkg::HOUR_W-1:0]             hour_now,
    output logic [tod_pkg::MIN_W-1:0]              minute_now,
    output logic [tod_pkg::MIN_W-1:0]              second_now,
    output logic                                   invalid,
    output logic signed [tod_pkg::FIELD_W-1:0]     difference
);
    import tod_pkg::*;

    logic                      va_reg, vb_reg;
    logic                      loada, loadb;
    logic [HOUR_W-1:0]         hour_a_reg;
    logic [REM_W-1:0]          rem_a_reg;
    logic                      inv_a_reg;
    logic signed [FIELD_W-1:0] diff_a_reg;
    logic [HOUR_W-1:0]         hour_b_reg;
    logic [MIN_W-1:0]          minute_b_reg;
    logic [MIN_W-1:0]          second_b_reg;
    logic                      inv_b_reg;
    logic signed [FIELD_W-1:0] diff_b_reg;

    logic [2*TIME_W-1:0]       h_prod;
    logic [HOUR_W-1:0]         h_est;
    logic [TIME_W-1:0]         rem_est;
    logic [HOUR_W-1:0]         hour_next;
    logic [REM_W-1:0]          rem_next;
    logic [2*REM_W-1:0]        m_prod;
    logic [MIN_W-1:0]          m_est;
    logic [REM_W-1:0]          sec_est;
    logic [MIN_W-1:0]          minute_next;
    logic [MIN_W-1:0]          second_next;

    assign loadb      = !vb_reg || out_ready;
    assign loada      = !va_reg || loadb;
    assign res_ready  = loada;
    assign out_valid  = vb_reg;
    assign hour_now   = hour_b_reg;
    assign minute_now = minute_b_reg;
    assign second_now = second_b_reg;
    assign invalid    = inv_b_reg;
    assign difference = diff_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (loada) va_reg <= res_valid;
            if (loadb) vb_reg <= va_reg;
        end
    end

    // hours by reciprocal multiplication, one correction step
    assign h_prod  = (2*TIME_W)'(res.now) * (2*TIME_W)'(RECIP_HOUR);
    assign h_est   = h_prod[TIME_W+HOUR_W-1:TIME_W];
    assign rem_est = res.now - TIME_W'(TIME_W'(h_est) * TIME_W'(HOUR_SECONDS));

    always_comb
    begin
        if (rem_est >= TIME_W'(HOUR_SECONDS))
        begin
            hour_next = h_est + HOUR_W'(1);
            rem_next  = REM_W'(rem_est - TIME_W'(HOUR_SECONDS));
        end
        else
        begin
            hour_next = h_est;
            rem_next  = REM_W'(rem_est);
        end
    end

    always_ff @(posedge clk)
    begin
        if (loada && res_valid)
        begin
            hour_a_reg <= hour_next;
            rem_a_reg  <= rem_next;
            inv_a_reg  <= res.invalid;
            diff_a_reg <= res.diff;
        end
    end

    // minutes and seconds of the remainder
    assign m_prod  = (2*REM_W)'(rem_a_reg) * (2*REM_W)'(RECIP_MINUTE);
    assign m_est   = m_prod[REM_W+MIN_W-1:REM_W];
    assign sec_est = rem_a_reg - REM_W'(REM_W'(m_est) * REM_W'(MINUTE_SECONDS));

    always_comb
    begin
        if (sec_est >= REM_W'(MINUTE_SECONDS))
        begin
            minute_next = m_est + MIN_W'(1);
            second_next = MIN_W'(sec_est - REM_W'(MINUTE_SECONDS));
        end
        else
        begin
            minute_next = m_est;
            second_next = MIN_W'(sec_est);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (loadb && va_reg)
        begin
            hour_b_reg   <= hour_a_reg;
            minute_b_reg <= minute_next;
            second_b_reg <= second_next;
            inv_b_reg    <= inv_a_reg;
            diff_b_reg   <= diff_a_reg;
        end
    end

endmodule

`default_nettype wire
